### hdl/mdtap_pkg.sv
// ----------------------------------------------------------------------------
// mdtap_pkg
// Shared types and constants for the MAC device table / access policy block.
// ----------------------------------------------------------------------------
package mdtap_pkg;

   localparam int MAC_W    = 48;
   localparam int IDX_W    = 4;    // width of request index and response entry
   localparam int MIN_W    = 11;   // minute of day
   localparam int SEC_W    = 32;
   localparam int CSR_IDX_W = 2;

   // Defaults loaded when a device is registered
   localparam logic [MIN_W-1:0] DEF_WIN_START = MIN_W'(6 * 60);
   localparam logic [MIN_W-1:0] DEF_WIN_END   = MIN_W'(21 * 60);
   localparam logic [MIN_W-1:0] DEF_QUOTA     = MIN_W'(480);
   localparam logic [5:0]       SEC_PER_MIN   = 6'd60;

   typedef enum logic [1:0] {
      ACT_LOOKUP    = 2'd0,
      ACT_REGISTER  = 2'd1,
      ACT_SET_RULES = 2'd2,
      ACT_EVALUATE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      BR_ALLOWED    = 3'd0,
      BR_MANUAL     = 3'd1,
      BR_UNAPPROVED = 3'd2,
      BR_NO_UPLINK  = 3'd3,
      BR_QUOTA      = 3'd4,
      BR_WINDOW     = 3'd5
   } reason_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEFAULT_ALLOW = 2'd0,
      CSR_UPLINK_UP     = 2'd1,
      CSR_TIME_VALID    = 2'd2
   } csr_index_type;

   typedef enum logic [0:0] {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_state_type;

   // Per-device rule record
   typedef struct packed {
      logic             manual_block;
      logic             approved;
      logic             quota_enabled;
      logic [MIN_W-1:0] quota_minutes;
      logic [SEC_W-1:0] used_seconds;
      logic             window_enabled;
      logic [MIN_W-1:0] window_start;
      logic [MIN_W-1:0] window_end;
   } rule_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // take the request, run the MAC compare, read the rules
      logic commit;    // resolve, write the table, load the response register
   } ctrl_cmd_type;

endpackage

### hdl/mac_device_table_access_policy.sv
// ----------------------------------------------------------------------------
// mac_device_table_access_policy
// Device MAC table with per-device access rules: lookup, register,
// set_rules and evaluate.
//
//   channel   dir   handshake            payload
//   req_*     in    valid / stall        action, mac, index, now_min, rules
//   rsp_*     out   valid / stall        entry_index, status, block_reason
//   csr_*     in    valid / ready        index, data (ready always high)
//
// Each request is accepted in FSM_IDLE, which compares the MAC against all
// entries and reads the rule memory; the commit in FSM_EXEC resolves, writes the
// table and loads the response register.
// A new request is taken while a response waits; the commit cycle holds
// until the response register is free.
// Synchronous reset clears the used flags and rule valid bits.
// ----------------------------------------------------------------------------
module mac_device_table_access_policy #(
   parameter int DEVICES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic [47:0]                       req_mac,
   input  logic [3:0]                        req_index,
   input  logic [10:0]                       req_now_min,
   input  logic                              req_manual_block,
   input  logic                              req_approved,
   input  logic                              req_quota_enabled,
   input  logic [10:0]                       req_quota_minutes,
   input  logic [31:0]                       req_used_seconds,
   input  logic                              req_window_enabled,
   input  logic [10:0]                       req_window_start,
   input  logic [10:0]                       req_window_end,
   // response
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [3:0]                        rsp_entry_index,
   output logic [1:0]                        rsp_status,
   output logic [2:0]                        rsp_block_reason,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic                              csr_data
);

   mdtap_pkg::ctrl_cmd_type cmd;
   mdtap_pkg::rule_type     req_rule;

   assign csr_ready = 1'b1;

   assign req_rule.manual_block   = req_manual_block;
   assign req_rule.approved       = req_approved;
   assign req_rule.quota_enabled  = req_quota_enabled;
   assign req_rule.quota_minutes  = req_quota_minutes;
   assign req_rule.used_seconds   = req_used_seconds;
   assign req_rule.window_enabled = req_window_enabled;
   assign req_rule.window_start   = req_window_start;
   assign req_rule.window_end     = req_window_end;

   mdtap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mdtap_datapath #(
      .DEVICES (DEVICES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_wr           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_action       (req_action),
      .req_mac          (req_mac),
      .req_index        (req_index),
      .req_now_min      (req_now_min),
      .req_rule         (req_rule),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_status       (rsp_status),
      .rsp_block_reason (rsp_block_reason)
   );

endmodule

### hdl/mdtap_ctrl.sv
// ----------------------------------------------------------------------------
// mdtap_ctrl
// Two-state sequencer: accepts a request, then commits it once the response
// register is free. Owns the request stall and the response valid.
// ----------------------------------------------------------------------------
module mdtap_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mdtap_pkg::ctrl_cmd_type cmd
);

   mdtap_pkg::fsm_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdtap_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      case (state_ff)
         mdtap_pkg::FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = mdtap_pkg::FSM_EXEC;
            end
         end
         mdtap_pkg::FSM_EXEC: begin
            // wait here while an older response is still held
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = mdtap_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = mdtap_pkg::FSM_IDLE;
         end
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/mdtap_datapath.sv
// ----------------------------------------------------------------------------
// mdtap_datapath
// Device table (parallel MAC compare), rule memory, policy evaluation,
// configuration registers and the response register.
// ----------------------------------------------------------------------------
module mdtap_datapath #(
   parameter int DEVICES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mdtap_pkg::ctrl_cmd_type           cmd,
   // config
   input  logic                              csr_wr,
   input  logic [mdtap_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic                              csr_data,
   // request payload
   input  logic [1:0]                        req_action,
   input  logic [mdtap_pkg::MAC_W-1:0]       req_mac,
   input  logic [mdtap_pkg::IDX_W-1:0]       req_index,
   input  logic [mdtap_pkg::MIN_W-1:0]       req_now_min,
   input  mdtap_pkg::rule_type               req_rule,
   // response payload
   output logic [mdtap_pkg::IDX_W-1:0]       rsp_entry_index,
   output logic [1:0]                        rsp_status,
   output logic [2:0]                        rsp_block_reason
);

   localparam int SLOT_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

   // configuration
   logic default_allow_ff, uplink_up_ff, time_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_allow_ff <= 1'b0;
         uplink_up_ff     <= 1'b0;
         time_valid_ff    <= 1'b0;
      end else if (csr_wr) begin
         case (mdtap_pkg::csr_index_type'(csr_index))
            mdtap_pkg::CSR_DEFAULT_ALLOW: default_allow_ff <= csr_data;
            mdtap_pkg::CSR_UPLINK_UP:     uplink_up_ff     <= csr_data;
            mdtap_pkg::CSR_TIME_VALID:    time_valid_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // table state
   logic [DEVICES-1:0]           used_ff;
   logic [mdtap_pkg::MAC_W-1:0]  mac_mem_ff [DEVICES];
   mdtap_pkg::rule_type          rule_mem_ff [DEVICES];
   logic [DEVICES-1:0]           rule_vld_ff;   // entry written since reset

   // captured request
   mdtap_pkg::action_type        action_ff;
   logic [mdtap_pkg::MAC_W-1:0]  mac_ff;
   logic [mdtap_pkg::IDX_W-1:0]  index_ff;
   logic [mdtap_pkg::MIN_W-1:0]  now_ff;
   mdtap_pkg::rule_type          rule_in_ff;
   logic [DEVICES-1:0]           hit_ff, hit_in;
   mdtap_pkg::rule_type          rule_rd_ff;
   logic                         rd_vld_ff;
   logic [SLOT_W-1:0]            rd_addr;

   // response register
   logic [mdtap_pkg::IDX_W-1:0]  entry_ff, entry_in;
   logic [1:0]                   status_ff, status_in;
   logic [2:0]                   reason_ff, reason_in;

   // write port
   logic                         wr_en;
   logic                         wr_new;      // register: claims the slot
   logic [SLOT_W-1:0]            wr_addr;
   mdtap_pkg::rule_type          wr_rule;

   // MAC compare against every used entry, done in the accept cycle
   always_comb begin
      for (int i = 0; i < DEVICES; i++) begin
         hit_in[i] = used_ff[i] && (mac_mem_ff[i] == req_mac);
      end
   end

   assign rd_addr = SLOT_W'(req_index);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= mdtap_pkg::action_type'(req_action);
         mac_ff     <= req_mac;
         index_ff   <= req_index;
         now_ff     <= req_now_min;
         rule_in_ff <= req_rule;
         hit_ff     <= hit_in;
         rule_rd_ff <= rule_mem_ff[rd_addr];
         rd_vld_ff  <= rule_vld_ff[rd_addr];
      end
   end

   // lowest matching and lowest free slot
   logic              hit_any, free_any;
   logic [SLOT_W-1:0] hit_idx, free_idx;

   always_comb begin
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = DEVICES - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            hit_any = 1'b1;
            hit_idx = SLOT_W'(i);
         end
         if (!used_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   // policy evaluation on the rules read at accept
   mdtap_pkg::rule_type    cur;
   logic [16:0]            quota_sec;
   logic                   in_window;
   logic                   in_range;
   logic [2:0]             eval_reason;

   assign cur       = rd_vld_ff ? rule_rd_ff : '0;
   assign quota_sec = 17'(cur.quota_minutes) * 17'(mdtap_pkg::SEC_PER_MIN);
   assign in_range  = 32'(index_ff) < DEVICES;

   always_comb begin
      if (cur.window_start == cur.window_end) begin
         in_window = 1'b1;
      end else if (cur.window_start < cur.window_end) begin
         in_window = (now_ff >= cur.window_start) && (now_ff < cur.window_end);
      end else begin
         // wraps past midnight
         in_window = (now_ff >= cur.window_start) || (now_ff < cur.window_end);
      end

      if (cur.manual_block) begin
         eval_reason = mdtap_pkg::BR_MANUAL;
      end else if (!cur.approved) begin
         eval_reason = mdtap_pkg::BR_UNAPPROVED;
      end else if (!uplink_up_ff) begin
         eval_reason = mdtap_pkg::BR_NO_UPLINK;
      end else if (cur.quota_enabled && (cur.used_seconds >= 32'(quota_sec))) begin
         eval_reason = mdtap_pkg::BR_QUOTA;
      end else if (time_valid_ff && cur.window_enabled && !in_window) begin
         eval_reason = mdtap_pkg::BR_WINDOW;
      end else begin
         eval_reason = mdtap_pkg::BR_ALLOWED;
      end
   end

   // resolve the request
   always_comb begin
      entry_in  = '0;
      status_in = mdtap_pkg::ST_OK;
      reason_in = mdtap_pkg::BR_ALLOWED;
      wr_en     = 1'b0;
      wr_new    = 1'b0;
      wr_addr   = SLOT_W'(index_ff);
      wr_rule   = rule_in_ff;
      case (action_ff)
         mdtap_pkg::ACT_LOOKUP: begin
            if (hit_any) begin
               entry_in = mdtap_pkg::IDX_W'(hit_idx);
            end else begin
               status_in = mdtap_pkg::ST_NOT_FOUND;
            end
         end
         mdtap_pkg::ACT_REGISTER: begin
            if (hit_any) begin
               entry_in = mdtap_pkg::IDX_W'(hit_idx);
            end else if (free_any) begin
               entry_in               = mdtap_pkg::IDX_W'(free_idx);
               wr_en                  = 1'b1;
               wr_new                 = 1'b1;
               wr_addr                = free_idx;
               wr_rule                = '0;
               wr_rule.approved       = default_allow_ff;
               wr_rule.quota_minutes  = mdtap_pkg::DEF_QUOTA;
               wr_rule.window_start   = mdtap_pkg::DEF_WIN_START;
               wr_rule.window_end     = mdtap_pkg::DEF_WIN_END;
            end else begin
               status_in = mdtap_pkg::ST_FULL;
            end
         end
         mdtap_pkg::ACT_SET_RULES: begin
            entry_in = index_ff;
            if (in_range) begin
               wr_en = 1'b1;
            end else begin
               status_in = mdtap_pkg::ST_NOT_FOUND;
            end
         end
         mdtap_pkg::ACT_EVALUATE: begin
            entry_in = index_ff;
            if (in_range) begin
               reason_in = eval_reason;
            end else begin
               status_in = mdtap_pkg::ST_NOT_FOUND;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         rule_vld_ff <= '0;
      end else if (cmd.commit && wr_en) begin
         rule_vld_ff[wr_addr] <= 1'b1;
         if (wr_new) begin
            used_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         rule_mem_ff[wr_addr] <= wr_rule;
         if (wr_new) begin
            mac_mem_ff[wr_addr] <= mac_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         entry_ff  <= entry_in;
         status_ff <= status_in;
         reason_ff <= reason_in;
      end
   end

   assign rsp_entry_index  = entry_ff;
   assign rsp_status       = status_ff;
   assign rsp_block_reason = reason_ff;

endmodule

### hdl/mdtap_checker.sv
// ----------------------------------------------------------------------------
// mdtap_checker
// Port-level checks for the device table block, bound to the top level.
// ----------------------------------------------------------------------------
module mdtap_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [2:0] rsp_block_reason
);

   // a stalled response stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // a new response only follows a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without request processing");

   // a block reason only comes with an ok status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_block_reason != mdtap_pkg::BR_ALLOWED)
         |-> (rsp_status == mdtap_pkg::ST_OK))
      else $error("block reason with error status");

endmodule

bind mac_device_table_access_policy mdtap_checker u_mdtap_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_block_reason (rsp_block_reason)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the device MAC table and access policy block.
// Requests come from a queue filled by a stimulus process. Each one is run
// through a local copy of the table when it is accepted, and every response
// is compared field by field with the oldest outstanding answer. A directed
// opener is followed by random phases, each under its own CSR setting.
// ----------------------------------------------------------------------------
module tb;

   localparam int DEVICES     = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   localparam logic [10:0] REG_WIN_START = 11'd360;
   localparam logic [10:0] REG_WIN_END   = 11'd1260;
   localparam logic [10:0] REG_QUOTA     = 11'd480;

   // bit 0 default_allow, bit 1 uplink_up, bit 2 time_valid
   localparam logic [2:0] CFG_PLAN [8] = '{3'b111, 3'b110, 3'b011, 3'b111,
                                           3'b101, 3'b010, 3'b111, 3'b100};

   typedef struct {
      mdtap_pkg::action_type action;
      logic [47:0]           mac;
      logic [3:0]            index;
      logic [10:0]           now_min;
      mdtap_pkg::rule_type   rules;
   } policy_request_type;

   typedef struct {
      logic [3:0]            entry;
      mdtap_pkg::status_type status;
      mdtap_pkg::reason_type reason;
   } policy_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [47:0] req_mac = '0;
   logic [3:0]  req_index = '0;
   logic [10:0] req_now_min = '0;
   logic        req_manual_block = 1'b0;
   logic        req_approved = 1'b0;
   logic        req_quota_enabled = 1'b0;
   logic [10:0] req_quota_minutes = '0;
   logic [31:0] req_used_seconds = '0;
   logic        req_window_enabled = 1'b0;
   logic [10:0] req_window_start = '0;
   logic [10:0] req_window_end = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_entry_index;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_block_reason;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic        csr_data = 1'b0;

   // local copy of the table and the CSRs
   logic                slot_taken [DEVICES];
   logic [47:0]         slot_addr  [DEVICES];
   mdtap_pkg::rule_type slot_rules [DEVICES];
   logic        cfg_default_allow = 1'b0;
   logic        cfg_uplink_up = 1'b0;
   logic        cfg_time_valid = 1'b0;

   policy_request_type queued_requests [$];
   policy_answer_type  table_answers [$];
   logic [47:0]        known_macs [$];
   policy_request_type on_offer;
   policy_answer_type  head_answer;

   int requests_taken = 0;
   int answers_seen = 0;
   int mismatches = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   mac_device_table_access_policy dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_mac            (req_mac),
      .req_index          (req_index),
      .req_now_min        (req_now_min),
      .req_manual_block   (req_manual_block),
      .req_approved       (req_approved),
      .req_quota_enabled  (req_quota_enabled),
      .req_quota_minutes  (req_quota_minutes),
      .req_used_seconds   (req_used_seconds),
      .req_window_enabled (req_window_enabled),
      .req_window_start   (req_window_start),
      .req_window_end     (req_window_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_status         (rsp_status),
      .rsp_block_reason   (rsp_block_reason),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Policy prediction
   // ------------------------------------------------------------------------
   function automatic mdtap_pkg::reason_type policy_verdict(mdtap_pkg::rule_type rr,
                                                             logic [10:0] now);
      logic [63:0] budget;
      logic        in_hours;
      budget = 64'(rr.quota_minutes) * 64'd60;
      if (rr.window_start == rr.window_end) begin
         in_hours = 1'b1;
      end else if (rr.window_start < rr.window_end) begin
         in_hours = (now >= rr.window_start) && (now < rr.window_end);
      end else begin
         in_hours = (now >= rr.window_start) || (now < rr.window_end);
      end
      if (rr.manual_block) return mdtap_pkg::BR_MANUAL;
      if (!rr.approved) return mdtap_pkg::BR_UNAPPROVED;
      if (!cfg_uplink_up) return mdtap_pkg::BR_NO_UPLINK;
      if (rr.quota_enabled && 64'(rr.used_seconds) >= budget) return mdtap_pkg::BR_QUOTA;
      if (cfg_time_valid && rr.window_enabled && !in_hours) return mdtap_pkg::BR_WINDOW;
      return mdtap_pkg::BR_ALLOWED;
   endfunction

   function automatic policy_answer_type table_apply(policy_request_type r);
      policy_answer_type   a;
      int                  hit;
      mdtap_pkg::rule_type fresh;
      a.entry  = '0;
      a.status = mdtap_pkg::ST_OK;
      a.reason = mdtap_pkg::BR_ALLOWED;
      hit = -1;
      if (r.action == mdtap_pkg::ACT_LOOKUP || r.action == mdtap_pkg::ACT_REGISTER) begin
         for (int i = 0; i < DEVICES; i++) begin
            if (hit < 0 && slot_taken[i] && slot_addr[i] == r.mac) hit = i;
         end
         if (r.action == mdtap_pkg::ACT_REGISTER && hit < 0) begin
            for (int i = 0; i < DEVICES; i++) begin
               if (hit < 0 && !slot_taken[i]) hit = i;
            end
            if (hit >= 0) begin
               fresh = '0;
               fresh.approved      = cfg_default_allow;
               fresh.quota_minutes = REG_QUOTA;
               fresh.window_start  = REG_WIN_START;
               fresh.window_end    = REG_WIN_END;
               slot_taken[hit] = 1'b1;
               slot_addr[hit]  = r.mac;
               slot_rules[hit] = fresh;
            end
         end
         if (hit >= 0) begin
            a.entry = 4'(hit);
         end else if (r.action == mdtap_pkg::ACT_LOOKUP) begin
            a.status = mdtap_pkg::ST_NOT_FOUND;
         end else begin
            a.status = mdtap_pkg::ST_FULL;
         end
      end else begin
         a.entry = r.index;
         if (int'(r.index) >= DEVICES) begin
            a.status = mdtap_pkg::ST_NOT_FOUND;
         end else if (r.action == mdtap_pkg::ACT_SET_RULES) begin
            slot_rules[r.index] = r.rules;
         end else begin
            a.reason = policy_verdict(slot_rules[r.index], r.now_min);
         end
      end
      return a;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [47:0] random_mac();
      return 48'({$urandom(), $urandom()});
   endfunction

   function automatic logic [10:0] random_minute();
      return 11'($urandom_range(1439));
   endfunction

   // mostly addresses already handed to register, some one bit off
   function automatic logic [47:0] pick_mac();
      int          p;
      int          b;
      logic [47:0] m;
      p = $urandom_range(99);
      if (known_macs.size() == 0 || p < 20) return random_mac();
      m = known_macs[$urandom_range(known_macs.size() - 1)];
      if (p < 40) begin
         b = $urandom_range(47);
         m[b] = ~m[b];
      end
      return m;
   endfunction

   function automatic mdtap_pkg::rule_type random_rules();
      mdtap_pkg::rule_type rr;
      int                  qm;
      int                  budget;
      rr.manual_block  = ($urandom_range(99) < 15);
      rr.approved      = ($urandom_range(99) < 80);
      rr.quota_enabled = 1'($urandom_range(1));
      case ($urandom_range(3))
         0:       qm = 0;
         1:       qm = 1440;
         default: qm = $urandom_range(1440);
      endcase
      rr.quota_minutes = 11'(qm);
      budget = qm * 60;
      case ($urandom_range(5))
         0:       rr.used_seconds = 32'(budget - 1);
         1:       rr.used_seconds = 32'(budget);
         2:       rr.used_seconds = 32'(budget + 1);
         3:       rr.used_seconds = 32'hFFFF_FFFF;
         4:       rr.used_seconds = '0;
         default: rr.used_seconds = $urandom();
      endcase
      rr.window_enabled = ($urandom_range(99) < 60);
      case ($urandom_range(4))
         0:       rr.window_start = '0;
         1:       rr.window_start = 11'd1439;
         default: rr.window_start = random_minute();
      endcase
      case ($urandom_range(4))
         0:       rr.window_end = rr.window_start;
         1:       rr.window_end = '0;
         2:       rr.window_end = 11'd1439;
         default: rr.window_end = random_minute();
      endcase
      return rr;
   endfunction

   // minute near a window boundary of the given rules, at either end of the day, or random
   function automatic logic [10:0] probe_minute(mdtap_pkg::rule_type rr);
      int m;
      case ($urandom_range(5))
         0:       m = int'(rr.window_start) + int'($urandom_range(2)) - 1;
         1:       m = int'(rr.window_end) + int'($urandom_range(2)) - 1;
         2:       m = 0;
         3:       m = 1439;
         default: m = $urandom_range(1439);
      endcase
      if (m < 0) m = 0;
      if (m > 1439) m = 1439;
      return 11'(m);
   endfunction

   task automatic queue_request(mdtap_pkg::action_type act, logic [47:0] mac,
                                logic [3:0] idx, logic [10:0] now,
                                mdtap_pkg::rule_type rr);
      policy_request_type r;
      r.action  = act;
      r.mac     = mac;
      r.index   = idx;
      r.now_min = now;
      r.rules   = rr;
      queued_requests.push_back(r);
   endtask

   // set_rules followed by evaluations on the same entry make up most of it
   task automatic queue_random_batch(int count);
      int                  made;
      int                  pick;
      int                  reps;
      mdtap_pkg::rule_type rr;
      logic [3:0]          idx;
      logic [47:0]         mac;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         idx  = 4'($urandom_range(15));
         if (pick < 45) begin
            rr = random_rules();
            queue_request(mdtap_pkg::ACT_SET_RULES, random_mac(), idx, random_minute(), rr);
            reps = $urandom_range(3, 1);
            repeat (reps) begin
               queue_request(mdtap_pkg::ACT_EVALUATE, random_mac(), idx, probe_minute(rr),
                             random_rules());
            end
            made += reps + 1;
         end else if (pick < 60) begin
            queue_request(mdtap_pkg::ACT_EVALUATE, random_mac(), idx, random_minute(),
                          random_rules());
            made++;
         end else if (pick < 82) begin
            queue_request(mdtap_pkg::ACT_LOOKUP, pick_mac(), idx, random_minute(),
                          random_rules());
            made++;
         end else begin
            mac = pick_mac();
            queue_request(mdtap_pkg::ACT_REGISTER, mac, idx, random_minute(),
                          random_rules());
            known_macs.push_back(mac);
            made++;
         end
      end
   endtask

   task automatic write_policy_reg(mdtap_pkg::csr_index_type which, logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (which)
         mdtap_pkg::CSR_DEFAULT_ALLOW: cfg_default_allow = value;
         mdtap_pkg::CSR_UPLINK_UP:     cfg_uplink_up = value;
         mdtap_pkg::CSR_TIME_VALID:    cfg_time_valid = value;
         default: ;
      endcase
   endtask

   task automatic load_policy_config(logic [2:0] setting);
      write_policy_reg(mdtap_pkg::CSR_DEFAULT_ALLOW, setting[0]);
      write_policy_reg(mdtap_pkg::CSR_UPLINK_UP, setting[1]);
      write_policy_reg(mdtap_pkg::CSR_TIME_VALID, setting[2]);
   endtask

   // sampled on the falling edge so the driver's updates have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || table_answers.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         for (int i = 0; i < DEVICES; i++) begin
            slot_taken[i] = 1'b0;
            slot_addr[i]  = '0;
            slot_rules[i] = '0;
         end
      end else begin
         if (req_valid && !req_stall) begin
            table_answers.push_back(table_apply(on_offer));
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (queued_requests.size() != 0 &&
                ((requests_taken >= 600 && requests_taken < 780) ||
                 $urandom_range(99) >= 33)) begin
               on_offer = queued_requests.pop_front();
               req_valid          <= 1'b1;
               req_action         <= on_offer.action;
               req_mac            <= on_offer.mac;
               req_index          <= on_offer.index;
               req_now_min        <= on_offer.now_min;
               req_manual_block   <= on_offer.rules.manual_block;
               req_approved       <= on_offer.rules.approved;
               req_quota_enabled  <= on_offer.rules.quota_enabled;
               req_quota_minutes  <= on_offer.rules.quota_minutes;
               req_used_seconds   <= on_offer.rules.used_seconds;
               req_window_enabled <= on_offer.rules.window_enabled;
               req_window_start   <= on_offer.rules.window_start;
               req_window_end     <= on_offer.rules.window_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor and receiver stall
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            answers_seen++;
            if (table_answers.size() == 0) begin
               mismatches++;
               $display("%0t: expected no response, actual entry %0d status %0d reason %0d",
                        $time, rsp_entry_index, rsp_status, rsp_block_reason);
            end else begin
               head_answer = table_answers.pop_front();
               if (rsp_entry_index !== head_answer.entry) begin
                  mismatches++;
                  $display("%0t: entry_index expected %0d actual %0d",
                           $time, head_answer.entry, rsp_entry_index);
               end
               if (rsp_status !== head_answer.status) begin
                  mismatches++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, head_answer.status, rsp_status);
               end
               if (rsp_block_reason !== head_answer.reason) begin
                  mismatches++;
                  $display("%0t: block_reason expected %0d actual %0d",
                           $time, head_answer.reason, rsp_block_reason);
               end
            end
         end
         // one long hold-off so the block backs up into the request side
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && answers_seen >= 350) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (answers_seen >= 600 && answers_seen < 780) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 33);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: no handshake on any channel for too long
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      load_policy_config(3'b000);

      // empty table, all CSRs clear
      queue_request(mdtap_pkg::ACT_LOOKUP, 48'h0, 4'd0, 11'd0, '0);
      queue_request(mdtap_pkg::ACT_EVALUATE, 48'h0, 4'd15, 11'd0, '0);
      queue_request(mdtap_pkg::ACT_REGISTER, 48'h0, 4'd0, 11'd0, '0);
      queue_request(mdtap_pkg::ACT_REGISTER, 48'hFFFF_FFFF_FFFF, 4'd15, 11'd1439, '0);
      queue_request(mdtap_pkg::ACT_REGISTER, 48'h0, 4'd0, 11'd0, '0);
      queue_request(mdtap_pkg::ACT_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'd0, 11'd0, '0);
      // rules written to an entry that was never registered
      queue_request(mdtap_pkg::ACT_SET_RULES, 48'h0, 4'd15, 11'd0,
                    mdtap_pkg::rule_type'{1'b1, 1'b1, 1'b1, 11'd1440, 32'hFFFF_FFFF,
                                          1'b1, 11'd1439, 11'd1439});
      queue_request(mdtap_pkg::ACT_EVALUATE, 48'h0, 4'd15, 11'd1439, '0);
      queue_request(mdtap_pkg::ACT_EVALUATE, 48'h0, 4'd0, 11'd720, '0);
      known_macs.push_back(48'h0);
      known_macs.push_back(48'hFFFF_FFFF_FFFF);
      wait_drained();

      load_policy_config(3'b111);
      queue_request(mdtap_pkg::ACT_REGISTER, 48'h2, 4'd0, 11'd0, '0);
      queue_request(mdtap_pkg::ACT_EVALUATE, 48'h0, 4'd2, 11'd0, '0);
      // quota one second short, then window edges
      queue_request(mdtap_pkg::ACT_SET_RULES, 48'h0, 4'd2, 11'd0,
                    mdtap_pkg::rule_type'{1'b0, 1'b1, 1'b1, 11'd10, 32'd599,
                                          1'b1, 11'd360, 11'd1260});
      queue_request(mdtap_pkg::ACT_EVALUATE, 48'h0, 4'd2, 11'd360, '0);
      queue_request(mdtap_pkg::ACT_EVALUATE, 48'h0, 4'd2, 11'd1260, '0);
      queue_request(mdtap_pkg::ACT_EVALUATE, 48'h0, 4'd2, 11'd359, '0);
      queue_request(mdtap_pkg::ACT_SET_RULES, 48'h0, 4'd2, 11'd0,
                    mdtap_pkg::rule_type'{1'b0, 1'b1, 1'b1, 11'd10, 32'd600,
                                          1'b1, 11'd360, 11'd1260});
      queue_request(mdtap_pkg::ACT_EVALUATE, 48'h0, 4'd2, 11'd700, '0);
      // window across midnight
      queue_request(mdtap_pkg::ACT_SET_RULES, 48'h0, 4'd2, 11'd0,
                    mdtap_pkg::rule_type'{1'b0, 1'b1, 1'b0, 11'd0, 32'd0,
                                          1'b1, 11'd1380, 11'd60});
      queue_request(mdtap_pkg::ACT_EVALUATE, 48'h0, 4'd2, 11'd1439, '0);
      queue_request(mdtap_pkg::ACT_EVALUATE, 48'h0, 4'd2, 11'd60, '0);
      queue_request(mdtap_pkg::ACT_EVALUATE, 48'h0, 4'd2, 11'd0, '0);
      // zero quota blocks even with nothing used
      queue_request(mdtap_pkg::ACT_SET_RULES, 48'h0, 4'd3, 11'd0,
                    mdtap_pkg::rule_type'{1'b0, 1'b1, 1'b1, 11'd0, 32'd0,
                                          1'b0, 11'd0, 11'd0});
      queue_request(mdtap_pkg::ACT_EVALUATE, 48'h0, 4'd3, 11'd0, '0);
      queue_request(mdtap_pkg::ACT_LOOKUP, 48'h2, 4'd0, 11'd0, '0);
      known_macs.push_back(48'h2);

      for (int p = 0; p < 8; p++) begin
         wait_drained();
         load_policy_config(CFG_PLAN[p]);
         queue_random_batch(140);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
